[rtl/core/fat_chain_block_allocator_unit_defines.svh]
// ----------------------------------------------------------------------------
// Block chain allocator assertion macros
// Shared checks written as concurrent properties on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FAT_CHAIN_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define FAT_CHAIN_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define FCBA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fcba check failed");

// Next-cycle implication.
`define FCBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fcba check failed");

`endif

[rtl/core/fcba_pkg.sv]
// ----------------------------------------------------------------------------
// Block chain allocator package
// Sizes, link and status codes, and the structs between the core modules.
// ----------------------------------------------------------------------------
package fcba_pkg;

  localparam int NUM_BLOCKS      = 1024;
  localparam int RESERVED_BLOCKS = 6;

  localparam int IDX_W  = $clog2(NUM_BLOCKS);
  localparam int CNT_W  = IDX_W + 1;
  localparam int BLK_W  = 11;
  localparam int LINK_W = 16;
  localparam int FUNC_W = 2;
  localparam int ST_W   = 2;

  localparam logic [LINK_W-1:0] LINK_END  = 16'hFFFF;
  localparam logic [LINK_W-1:0] LINK_FREE = 16'h0000;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_NEXT  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [LINK_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    logic              valid;
    logic [LINK_W-1:0] block_result;
    logic [ST_W-1:0]   status;
  } res_t;

endpackage

[rtl/core/fcba_link_mem.sv]
// ----------------------------------------------------------------------------
// Link table storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fcba_link_mem (
  input  logic                          clk,
  input  fcba_pkg::mem_req_t            mem_req,
  output logic [fcba_pkg::LINK_W-1:0]   rd_data
);

  logic [fcba_pkg::LINK_W-1:0] mem [fcba_pkg::NUM_BLOCKS];
  logic [fcba_pkg::LINK_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
    rd_data_r <= mem[mem_req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/fcba_seq.sv]
// ----------------------------------------------------------------------------
// Block chain allocator sequencer
// Clears the table after reset, then runs one request at a time: decode,
// first-fit scan with a single compare/increment unit, link reads and table updates.
// ----------------------------------------------------------------------------
module fcba_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          req_valid,
  input  logic [fcba_pkg::FUNC_W-1:0]   req_func,
  input  logic [fcba_pkg::BLK_W-1:0]    req_block,
  input  logic                          out_ready,
  input  logic [fcba_pkg::LINK_W-1:0]   rd_data,
  output logic                          idle,
  output fcba_pkg::res_t                res,
  output fcba_pkg::mem_req_t            mem_req
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_RD_WAIT,
    S_SCAN,
    S_WR_END,
    S_WR_PRED,
    S_DONE
  } state_t;

  state_t                          state_r, state_nxt;
  logic [fcba_pkg::FUNC_W-1:0]     func_r, func_nxt;
  logic [fcba_pkg::BLK_W-1:0]      blk_r, blk_nxt;
  logic [fcba_pkg::CNT_W-1:0]      scan_r, scan_nxt;
  logic [fcba_pkg::IDX_W-1:0]      chk_r, chk_nxt;
  logic                            chk_vld_r, chk_vld_nxt;
  logic [fcba_pkg::IDX_W-1:0]      clr_r, clr_nxt;
  logic [fcba_pkg::LINK_W-1:0]     res_blk_r, res_blk_nxt;
  logic [fcba_pkg::ST_W-1:0]       res_st_r, res_st_nxt;

  logic                            bad_blk;
  logic [fcba_pkg::IDX_W-1:0]      blk_idx;
  logic [fcba_pkg::LINK_W-1:0]     found_blk;
  logic                            scan_more;

  assign blk_idx   = fcba_pkg::IDX_W'(blk_r - fcba_pkg::BLK_W'(1));
  assign found_blk = fcba_pkg::LINK_W'({1'b0, chk_r}) + fcba_pkg::LINK_W'(1);
  assign scan_more = (scan_r < fcba_pkg::CNT_W'(fcba_pkg::NUM_BLOCKS));

  always_comb begin
    bad_blk = (blk_r > fcba_pkg::BLK_W'(fcba_pkg::NUM_BLOCKS));
    if ((func_r == fcba_pkg::FUNC_FREE) || (func_r == fcba_pkg::FUNC_NEXT)) begin
      bad_blk = bad_blk || (blk_r == '0);
    end else if (func_r != fcba_pkg::FUNC_ALLOC) begin
      bad_blk = 1'b1;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    func_nxt    = func_r;
    blk_nxt     = blk_r;
    scan_nxt    = scan_r;
    chk_nxt     = chk_r;
    chk_vld_nxt = chk_vld_r;
    clr_nxt     = clr_r;
    res_blk_nxt = res_blk_r;
    res_st_nxt  = res_st_r;
    mem_req     = '0;
    mem_req.raddr = blk_idx;

    case (state_r)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_r;
        mem_req.wdata = ({1'b0, clr_r} < fcba_pkg::CNT_W'(fcba_pkg::RESERVED_BLOCKS)) ?
                        fcba_pkg::LINK_END : fcba_pkg::LINK_FREE;
        clr_nxt = clr_r + fcba_pkg::IDX_W'(1);
        if (clr_r == fcba_pkg::IDX_W'(fcba_pkg::NUM_BLOCKS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          func_nxt  = req_func;
          blk_nxt   = req_block;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        res_blk_nxt = '0;
        res_st_nxt  = fcba_pkg::ST_OK;
        if (bad_blk) begin
          res_st_nxt = fcba_pkg::ST_RANGE;
          state_nxt  = S_DONE;
        end else if (func_r == fcba_pkg::FUNC_FREE) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = blk_idx;
          mem_req.wdata = fcba_pkg::LINK_FREE;
          state_nxt     = S_DONE;
        end else if (func_r == fcba_pkg::FUNC_NEXT) begin
          state_nxt = S_RD_WAIT;
        end else begin
          scan_nxt    = '0;
          chk_vld_nxt = 1'b0;
          state_nxt   = S_SCAN;
        end
      end
      S_RD_WAIT: begin
        res_blk_nxt = rd_data;
        state_nxt   = S_DONE;
      end
      S_SCAN: begin
        // Issue one address and check the previous one every cycle.
        mem_req.raddr = scan_r[fcba_pkg::IDX_W-1:0];
        chk_nxt       = scan_r[fcba_pkg::IDX_W-1:0];
        chk_vld_nxt   = scan_more;
        if (scan_more) begin
          scan_nxt = scan_r + fcba_pkg::CNT_W'(1);
        end
        if (chk_vld_r && (rd_data == fcba_pkg::LINK_FREE)) begin
          chk_nxt     = chk_r;
          res_blk_nxt = found_blk;
          state_nxt   = S_WR_END;
        end else if (!chk_vld_r && !scan_more) begin
          res_st_nxt = fcba_pkg::ST_FULL;
          state_nxt  = S_DONE;
        end
      end
      S_WR_END: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = chk_r;
        mem_req.wdata = fcba_pkg::LINK_END;
        state_nxt     = (blk_r != '0) ? S_WR_PRED : S_DONE;
      end
      S_WR_PRED: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = blk_idx;
        mem_req.wdata = res_blk_r;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      chk_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      chk_vld_r <= chk_vld_nxt;
    end
    func_r    <= func_nxt;
    blk_r     <= blk_nxt;
    scan_r    <= scan_nxt;
    chk_r     <= chk_nxt;
    res_blk_r <= res_blk_nxt;
    res_st_r  <= res_st_nxt;
  end

  assign idle             = (state_r == S_IDLE);
  assign res.valid        = (state_r == S_DONE) && out_ready;
  assign res.block_result = res_blk_r;
  assign res.status       = res_st_r;

endmodule

[rtl/core/fat_chain_block_allocator_unit.sv]
// ----------------------------------------------------------------------------
// Block chain allocator unit
// File-allocation link table with allocate, free and next-link requests.
// ----------------------------------------------------------------------------
// The unit keeps one 16-bit link per disk block (1024 blocks, numbered from
// 1): 0 is a free block, 65535 the end of a chain, anything else the next
// block. After reset a clearing pass writes the table (the first 6 entries
// end-of-chain, the rest free); in_stall stays high during it. One request
// is handled at a time. Free clears the entry in the decode state; next
// reads the entry and returns it after the read-wait state. Allocate walks
// the table first-fit through a single address counter and compare unit,
// one entry per cycle from the memory's one read port, then writes the end
// mark into the found entry and, when a predecessor is given, links it to
// the found block; a full table answers with the full status. A finished
// result sits in the output register, so the next input beat is taken while
// it waits for the consumer.
// ----------------------------------------------------------------------------
`include "fat_chain_block_allocator_unit_defines.svh"

module fat_chain_block_allocator_unit (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [fcba_pkg::FUNC_W-1:0]   in_func,
  input  logic [fcba_pkg::BLK_W-1:0]    in_block,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fcba_pkg::LINK_W-1:0]   out_block_result,
  output logic [fcba_pkg::ST_W-1:0]     out_status
);

  logic                          seq_idle;
  logic                          in_accept;
  logic                          out_ready;
  fcba_pkg::res_t                res;
  fcba_pkg::mem_req_t            mem_req;
  logic [fcba_pkg::LINK_W-1:0]   rd_data;

  logic                          out_valid_r, out_valid_nxt;
  logic [fcba_pkg::LINK_W-1:0]   out_block_result_r;
  logic [fcba_pkg::ST_W-1:0]     out_status_r;

  // Take a beat only while the sequencer is idle.
  assign in_stall  = !seq_idle;
  assign in_accept = in_valid && !in_stall;

  // Output register can load when empty or when its beat leaves this cycle.
  assign out_ready = !out_valid_r || !out_stall;

  fcba_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_accept),
    .req_func  (in_func),
    .req_block (in_block),
    .out_ready (out_ready),
    .rd_data   (rd_data),
    .idle      (seq_idle),
    .res       (res),
    .mem_req   (mem_req)
  );

  fcba_link_mem u_mem (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  // Hold the result until taken; drop valid once the beat leaves.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res.valid) begin
      out_block_result_r <= res.block_result;
      out_status_r       <= res.status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_block_result = out_block_result_r;
  assign out_status       = out_status_r;

  // A new result never overwrites one the consumer has not taken.
  `FCBA_ASSERT_NOW(a_no_overwrite, res.valid, !out_valid_r || !out_stall)
  // After taking a beat the unit is busy with it.
  `FCBA_ASSERT_NEXT(a_busy_after_accept, in_accept, in_stall)
  // Failed requests report block number zero.
  `FCBA_ASSERT_NOW(a_fail_zero, res.valid && (res.status != fcba_pkg::ST_OK),
                   res.block_result == '0)
  // Table is never written while idle.
  `FCBA_ASSERT_NOW(a_idle_no_write, seq_idle, !mem_req.we)

endmodule
